// File: sv/frp_pkg.sv
// ----------------------------------------------------------------------------
// frp_pkg: shared types and constants for the FASTQ record parser
// Character codes, line phases, result tags, status codes, base code
// helpers and the result item layout used by the parser and its queue.
// ----------------------------------------------------------------------------
`default_nettype none

package frp_pkg;

	// Default longest stored read and depth of the result queue
	localparam int MAX_READ_LEN = 1024;
	localparam int OUT_DEPTH    = 4;

	// Characters of interest
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_G    = 8'h47;
	localparam logic [7:0] CH_T    = 8'h54;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SP   = 8'h20;

	// Base codes as kept in the complement store
	localparam logic [2:0] BC_A    = 3'd0;
	localparam logic [2:0] BC_C    = 3'd1;
	localparam logic [2:0] BC_G    = 3'd2;
	localparam logic [2:0] BC_T    = 3'd3;
	localparam logic [2:0] BC_N    = 3'd4;
	localparam logic [2:0] BC_HASH = 3'd5;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SEQ,
		PH_PLUS,
		PH_QUAL
	} phase_t;

	typedef enum logic [1:0] {
		TAG_NAME,
		TAG_SEQ,
		TAG_QUAL,
		TAG_END
	} tag_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_SEQ_LONG,
		ST_QUAL_SHORT,
		ST_QUAL_LONG
	} status_t;

	typedef struct packed {
		tag_t        field_tag;
		logic [7:0]  data_byte;
		logic [7:0]  revcomp_byte;
		logic        revcomp_valid;
		logic [15:0] record_bytes;
		status_t     record_status;
		logic        end_of_record;
	} out_item_t;

	// Map a raw sequence byte to its base code; anything unknown is N
	function automatic logic [2:0] base_code(input logic [7:0] c);
		logic [2:0] code;
		case (c)
			CH_A:    code = BC_A;
			CH_C:    code = BC_C;
			CH_G:    code = BC_G;
			CH_T:    code = BC_T;
			CH_HASH: code = BC_HASH;
			default: code = BC_N;
		endcase
		return code;
	endfunction

	// Complement of a base code: A-T, C-G, N and # map to themselves
	function automatic logic [2:0] base_comp(input logic [2:0] code);
		logic [2:0] comp;
		case (code)
			BC_A:    comp = BC_T;
			BC_C:    comp = BC_G;
			BC_G:    comp = BC_C;
			BC_T:    comp = BC_A;
			BC_HASH: comp = BC_HASH;
			default: comp = BC_N;
		endcase
		return comp;
	endfunction

	// Character of a base code; the two unused codes wrap modulo six
	function automatic logic [7:0] base_chr(input logic [2:0] code);
		logic [7:0] chr;
		case (code)
			BC_A:    chr = CH_A;
			BC_C:    chr = CH_C;
			BC_G:    chr = CH_G;
			BC_T:    chr = CH_T;
			BC_N:    chr = CH_N;
			BC_HASH: chr = CH_HASH;
			default: chr = code[0] ? CH_C : CH_A;
		endcase
		return chr;
	endfunction

endpackage

`default_nettype wire

// File: sv/frp_in_if.sv
// ----------------------------------------------------------------------------
// frp_in_if: raw byte channel
// Valid/ready channel that carries one FASTQ stream byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface frp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// File: sv/frp_out_if.sv
// ----------------------------------------------------------------------------
// frp_out_if: parser result channel
// Valid/ready channel that carries one parsed result item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface frp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  field_tag;
	logic [7:0]  data_byte;
	logic [7:0]  revcomp_byte;
	logic        revcomp_valid;
	logic [15:0] record_bytes;
	logic [1:0]  record_status;
	logic        end_of_record;

	modport source (
		output valid, output field_tag, output data_byte, output revcomp_byte,
		output revcomp_valid, output record_bytes, output record_status,
		output end_of_record, input ready
	);
	modport sink (
		input valid, input field_tag, input data_byte, input revcomp_byte,
		input revcomp_valid, input record_bytes, input record_status,
		input end_of_record, output ready
	);
endinterface

`default_nettype wire

// File: sv/frp_out_fifo.sv
// ----------------------------------------------------------------------------
// frp_out_fifo: result queue
// Small register queue between the parser pipeline and the result channel.
// The writer never pushes into a full queue; it tracks room through count.
// ----------------------------------------------------------------------------
`default_nettype none

module frp_out_fifo #(
	parameter int DEPTH = frp_pkg::OUT_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire frp_pkg::out_item_t       push_item,
	output logic [$clog2(DEPTH+1)-1:0]    count,
	frp_out_if.source                     result
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	frp_pkg::out_item_t slot_q [DEPTH];
	logic [PW-1:0]      wp_q;
	logic [PW-1:0]      rp_q;
	logic [CW-1:0]      count_q;
	logic               pop;
	frp_pkg::out_item_t head;

	// Present the oldest item
	assign head                 = slot_q[rp_q];
	assign result.valid         = (count_q != '0);
	assign result.field_tag     = head.field_tag;
	assign result.data_byte     = head.data_byte;
	assign result.revcomp_byte  = head.revcomp_byte;
	assign result.revcomp_valid = head.revcomp_valid;
	assign result.record_bytes  = head.record_bytes;
	assign result.record_status = head.record_status;
	assign result.end_of_record = head.end_of_record;
	assign pop                  = result.valid && result.ready;
	assign count                = count_q;

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

// File: sv/fastq_record_parse_revcomp.sv
// ----------------------------------------------------------------------------
// fastq_record_parse_revcomp: FASTQ record parser with reverse complement
// Parses a raw FASTQ byte stream into name, sequence, quality and record-end
// items; quality items with a stored base carry the reverse-complement base.
// ----------------------------------------------------------------------------
// Usage:
//   stream carries one raw FASTQ byte per item; result carries parsed items
//   (name byte, normalized base, quality byte with its reverse-complement
//   base, or record end with byte count and status).
//   A result is registered in the parse stage, then queued, and then offered.
//   Throughput: one byte per cycle while the queue has room. A carriage return
//   not followed by a newline yields two byte events and stalls the stream
//   while the second is replayed, as the parse stage handles one byte event
//   per cycle on the store's single port and one result leaves per cycle.
//   Sequence bases are written to the complement store in the sequence
//   line and read back in reverse order in the quality line; the two lines
//   are separated by the plus line, so a read never meets a pending write.
//   Reset clears the line state and counters; the complement store is not
//   cleared and needs no clearing pass, as only positions written in the
//   same record are read.
//   A four-item result queue absorbs receiver stalls; stream.ready drops
//   when the queue and the stage in flight would overflow it.
// ----------------------------------------------------------------------------
`default_nettype none

module fastq_record_parse_revcomp #(
	parameter int MAX_READ_LEN = frp_pkg::MAX_READ_LEN
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	frp_in_if.sink     stream,
	frp_out_if.source  result
);

	localparam int CW  = $clog2(MAX_READ_LEN + 2);
	localparam int AW  = $clog2(MAX_READ_LEN);
	localparam int OCW = $clog2(frp_pkg::OUT_DEPTH + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_READ_LEN);

	// Line state
	frp_pkg::phase_t phase_q, phase_n;
	logic            name_done_q, name_done_n;
	logic            held_q, held_n;
	logic [CW-1:0]   sc_q, sc_n;
	logic [CW-1:0]   qc_q, qc_n;
	logic [15:0]     bt_q, bt_n;
	logic            err_q, err_n;
	logic            pend_q, pend_n;
	logic [7:0]      pend_byte_q, pend_byte_n;

	// Complement store
	logic [2:0]      store_q [MAX_READ_LEN];
	logic [2:0]      rd_data_q;
	logic            wr_en, rd_en;
	logic [AW-1:0]   wr_addr, rd_addr;
	logic [2:0]      wr_data;
	logic [CW-1:0]   rd_idx;

	// Byte event and result
	logic            credit, byte_acc;
	logic            ev_vld, ev_first;
	logic [7:0]      ev_c;
	logic [2:0]      code;
	logic [15:0]     bt_inc;
	logic            res_vld;
	frp_pkg::out_item_t res, res_s1, push_item;
	logic            res_vld_s1;
	logic [OCW-1:0]  fifo_count;

	// Accept only while the queue has room for everything in flight
	assign credit   = (fifo_count + OCW'(res_vld_s1)) < OCW'(frp_pkg::OUT_DEPTH);
	assign stream.ready = !pend_q && credit;
	assign byte_acc = stream.valid && stream.ready;

	assign bt_inc  = (bt_q == 16'hFFFF) ? bt_q : bt_q + 16'd1;
	assign rd_idx  = sc_q - qc_q - CW'(1);
	assign rd_addr = rd_idx[AW-1:0];
	assign wr_addr = sc_q[AW-1:0];
	assign wr_data = frp_pkg::base_comp(code);

	// Turn bytes into events, then walk the line state for one event
	always_comb begin
		ev_vld      = 1'b0;
		ev_first    = 1'b0;
		ev_c        = stream.in_byte;
		held_n      = held_q;
		pend_n      = pend_q;
		pend_byte_n = pend_byte_q;
		bt_n        = bt_q;
		phase_n     = phase_q;
		name_done_n = name_done_q;
		sc_n        = sc_q;
		qc_n        = qc_q;
		err_n       = err_q;
		wr_en       = 1'b0;
		rd_en       = 1'b0;
		res_vld     = 1'b0;
		res         = '0;

		// Replay the byte that followed a held carriage return
		if (pend_q) begin
			if (credit) begin
				ev_vld = 1'b1;
				ev_c   = pend_byte_q;
				pend_n = 1'b0;
			end
		end else if (byte_acc) begin
			bt_n = bt_inc;
			if (bt_q == 16'd0) begin
				ev_vld   = 1'b1;
				ev_first = 1'b1;
			end else if (stream.in_byte == frp_pkg::CH_CR) begin
				ev_vld = held_q;
				ev_c   = frp_pkg::CH_CR;
				held_n = 1'b1;
			end else if (held_q) begin
				held_n = 1'b0;
				ev_vld = 1'b1;
				if (stream.in_byte != frp_pkg::CH_LF) begin
					ev_c        = frp_pkg::CH_CR;
					pend_n      = 1'b1;
					pend_byte_n = stream.in_byte;
				end
			end else begin
				ev_vld = 1'b1;
			end
		end

		code = frp_pkg::base_code(ev_c);

		if (ev_vld) begin
			case (phase_q)
				frp_pkg::PH_HEADER: begin
					if (ev_c == frp_pkg::CH_LF) begin
						phase_n = frp_pkg::PH_SEQ;
					end else if (ev_first) begin
						// drop the record marker
					end else if (ev_c == frp_pkg::CH_SP) begin
						name_done_n = 1'b1;
					end else if (!name_done_q) begin
						res_vld       = 1'b1;
						res.field_tag = frp_pkg::TAG_NAME;
						res.data_byte = ev_c;
					end
				end
				frp_pkg::PH_SEQ: begin
					if (ev_c == frp_pkg::CH_LF) begin
						phase_n = frp_pkg::PH_PLUS;
					end else begin
						if (sc_q < MAX_C) begin
							wr_en = 1'b1;
						end else begin
							err_n = 1'b1;
						end
						if (sc_q <= MAX_C) begin
							sc_n = sc_q + CW'(1);
						end
						res_vld       = 1'b1;
						res.field_tag = frp_pkg::TAG_SEQ;
						res.data_byte = frp_pkg::base_chr(code);
					end
				end
				frp_pkg::PH_PLUS: begin
					if (ev_c == frp_pkg::CH_LF) begin
						phase_n = frp_pkg::PH_QUAL;
					end
				end
				frp_pkg::PH_QUAL: begin
					if (ev_c == frp_pkg::CH_LF) begin
						res_vld           = 1'b1;
						res.field_tag     = frp_pkg::TAG_END;
						res.record_bytes  = bt_inc;
						res.end_of_record = 1'b1;
						if (err_q) begin
							res.record_status = frp_pkg::ST_SEQ_LONG;
						end else if (qc_q < sc_q) begin
							res.record_status = frp_pkg::ST_QUAL_SHORT;
						end else if (qc_q > sc_q) begin
							res.record_status = frp_pkg::ST_QUAL_LONG;
						end else begin
							res.record_status = frp_pkg::ST_OK;
						end
						// Start the next record
						phase_n     = frp_pkg::PH_HEADER;
						name_done_n = 1'b0;
						held_n      = 1'b0;
						sc_n        = '0;
						qc_n        = '0;
						bt_n        = 16'd0;
						err_n       = 1'b0;
					end else begin
						rd_en = !err_q && (qc_q < sc_q);
						if (qc_q <= MAX_C) begin
							qc_n = qc_q + CW'(1);
						end
						res_vld           = 1'b1;
						res.field_tag     = frp_pkg::TAG_QUAL;
						res.data_byte     = ev_c;
						res.revcomp_valid = rd_en;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Hold line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= frp_pkg::PH_HEADER;
			name_done_q <= 1'b0;
			held_q      <= 1'b0;
			sc_q        <= '0;
			qc_q        <= '0;
			bt_q        <= 16'd0;
			err_q       <= 1'b0;
			pend_q      <= 1'b0;
			res_vld_s1  <= 1'b0;
		end else begin
			phase_q     <= phase_n;
			name_done_q <= name_done_n;
			held_q      <= held_n;
			sc_q        <= sc_n;
			qc_q        <= qc_n;
			bt_q        <= bt_n;
			err_q       <= err_n;
			pend_q      <= pend_n;
			res_vld_s1  <= res_vld;
		end
	end

	// Payload of the parse stage
	always_ff @(posedge clk) begin
		pend_byte_q <= pend_byte_n;
		res_s1      <= res;
	end

	// Write and read the complement store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	// Merge the read-back base into the result
	always_comb begin
		push_item = res_s1;
		push_item.revcomp_byte = res_s1.revcomp_valid ? frp_pkg::base_chr(rd_data_q) : 8'h00;
	end

	frp_out_fifo #(
		.DEPTH(frp_pkg::OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_vld_s1),
		.push_item (push_item),
		.count     (fifo_count),
		.result    (result)
	);

`ifndef SYNTH
	a_store_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("complement store written and read in one cycle");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_count + OCW'(res_vld_s1)) <= OCW'(frp_pkg::OUT_DEPTH))
		else $error("result queue overcommitted");

	a_read_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (res_vld_s1 && res_s1.revcomp_valid))
		else $error("store read without a matching quality item");

	a_record_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_vld && phase_q == frp_pkg::PH_QUAL && ev_c == frp_pkg::CH_LF)
		|=> (bt_q == 16'd0 && phase_q == frp_pkg::PH_HEADER && !held_q && sc_q == '0))
		else $error("record end did not restart the line state");
`endif

endmodule

`default_nettype wire
